### src/cvlg_pkg.sv
// Shared constants for the composite video line generator.
package cvlg_pkg;

    localparam int VRAM_BYTES = 96;
    localparam int VADDR_W    = 7;
    localparam int VDATA_W    = 8;
    localparam int LINE_W     = 9;
    localparam int FAL_W      = 8;
    localparam int ROW_W      = 5;
    localparam int X_W        = 7;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [VADDR_W-1:0] VRAM_LAST = VADDR_W'(VRAM_BYTES - 1);
    localparam logic [IDX_W-1:0]   VRAM_SIZE = IDX_W'(VRAM_BYTES);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES        = 1'b1;

    localparam logic [FAL_W-1:0]  FAL_RESET       = 8'd30;
    localparam logic [LINE_W-1:0] LPF_RESET       = 9'd262;
    localparam logic [LINE_W-1:0] SYNC_LONG_LINE  = 9'd1;
    localparam logic [LINE_W-1:0] SYNC_SHORT_LINE = 9'd10;

endpackage

### src/composite_video_line_generator_unit.sv
// Composite video line generator top level: line sequencer, pixel fetch and output register.
//
//   port group   dir  carries
//   s_axis_*     in   write and line-tick items
//   m_axis_*     out  status or pixel results, tlast on the final one of a line
//   i_cfg_*      in   register writes (first_active_line, lines_per_frame)
//
// For a displayed line, one state classifies the line, one turns the line
// offset into a dot row by a reciprocal multiply, then one pixel is read
// from the pixel RAM per cycle while m_axis does not stall. After reset a
// clearing pass zeroes the pixel RAM and no item is taken meanwhile. A stall
// on m_axis holds the pixel fetch.
module composite_video_line_generator_unit import cvlg_pkg::*; #(
    parameter int WIDTH      = 32,
    parameter int DOT_ROWS   = 24,
    parameter int DOT_HEIGHT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // vram_address[6:0], vram_data[14:7], zero
    input  logic                 s_axis_tuser,  // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // sync_long[0], pixel[1], frame_tick[2], zero
    output logic                 m_axis_tuser,  // pixel_valid
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]    i_cfg_data
);

    localparam logic [LINE_W-1:0] ACTIVE_LINES = LINE_W'(DOT_ROWS * DOT_HEIGHT);
    localparam logic [X_W-1:0]    X_LAST       = X_W'(WIDTH - 1);
    localparam logic [IDX_W-1:0]  PIX_PER_ROW  = IDX_W'(WIDTH);

    // row = offset / DOT_HEIGHT as (offset * ceil(2^13 / DOT_HEIGHT)) >> 13,
    // exact for any 9-bit offset and DOT_HEIGHT up to 16
    localparam int ROW_SHIFT = 13;
    localparam int RECIP_W   = 14;
    localparam int PROD_W    = LINE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] ROW_RECIP =
        RECIP_W'(((1 << ROW_SHIFT) + DOT_HEIGHT - 1) / DOT_HEIGHT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLASS = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_PIX   = 3'd4;

    logic [2:0]         r_state;
    logic [VADDR_W-1:0] r_clr_addr;
    logic [FAL_W-1:0]   r_fal;
    logic [LINE_W-1:0]  r_lpf;
    logic [LINE_W-1:0]  r_line;
    logic               r_sync;
    logic [LINE_W-1:0]  r_rem;
    logic [ROW_W-1:0]   r_row;
    logic [X_W-1:0]     r_x;
    logic [IDX_W-1:0]   r_idx;
    logic               r_pend;
    logic               r_pend_zero;
    logic               r_pend_last;
    logic [2:0]         r_pend_bit;
    logic               r_out_valid;
    logic               r_out_sync;
    logic               r_out_pixel;
    logic               r_out_pvalid;
    logic               r_out_tick;
    logic               r_out_last;

    logic               w_accept;
    logic               w_blank;
    logic [LINE_W-1:0]  w_diff;
    logic               w_past;
    logic               w_wrap;
    logic               w_status_load;
    logic               n_sync;
    logic [ROW_W-1:0]   w_row;
    logic               w_out_free;
    logic               w_move;
    logic               w_issue;
    logic               w_wr_en;
    logic [VADDR_W-1:0] w_wr_addr;
    logic [VDATA_W-1:0] w_wr_data;
    logic               w_rd_en;
    logic [VDATA_W-1:0] w_rd_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // line classification
    assign w_blank = (r_line <= {1'b0, r_fal});
    assign w_diff  = r_line - {1'b0, r_fal};
    assign w_past  = (w_diff >= ACTIVE_LINES);
    assign w_wrap  = (r_line >= r_lpf);

    assign w_row = ROW_W'((PROD_W'(r_rem) * PROD_W'(ROW_RECIP)) >> ROW_SHIFT);

    always_comb begin
        n_sync = r_sync;
        if (w_blank && r_line == SYNC_LONG_LINE) begin
            n_sync = 1'b1;
        end else if (w_blank && r_line == SYNC_SHORT_LINE) begin
            n_sync = 1'b0;
        end
    end

    // pixel fetch pipeline: read issued, data lands in the RAM's registered read output
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_move        = r_pend && w_out_free;
    assign w_issue       = (r_state == ST_PIX) && (!r_pend || w_move);
    assign w_status_load = (r_state == ST_CLASS) && (w_blank || w_past)
                           && w_out_free && !r_pend;
    assign w_rd_en       = w_issue && (r_idx < VRAM_SIZE);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_addr;
        w_wr_data = '0;
        if (r_state == ST_CLEAR) begin
            w_wr_en = 1'b1;
        end else if (w_accept && s_axis_tuser == CMD_WRITE) begin
            w_wr_addr = s_axis_tdata[VADDR_W-1:0];
            w_wr_data = s_axis_tdata[VADDR_W+VDATA_W-1:VADDR_W];
            w_wr_en   = (s_axis_tdata[VADDR_W-1:0] <= VRAM_LAST);
        end
    end

    cvlg_ram #(
        .DATA_W (VDATA_W),
        .DEPTH  (VRAM_BYTES)
    ) u_vram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[VADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_fal       <= FAL_RESET;
            r_lpf       <= LPF_RESET;
            r_line      <= '0;
            r_sync      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_row       <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    CFG_FIRST_ACTIVE: r_fal <= i_cfg_data[FAL_W-1:0];
                    CFG_LINES:        r_lpf <= i_cfg_data;
                    default:          ;
                endcase
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == VRAM_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept && s_axis_tuser == CMD_TICK) begin
                        r_line  <= r_line + 1'b1;
                        r_state <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    if (w_blank || w_past) begin
                        if (w_status_load) begin
                            r_sync <= n_sync;
                            if (!w_blank && w_wrap) begin
                                r_line <= '0;
                            end
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_rem   <= w_diff;
                        r_row   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_row   <= w_row;
                    r_x     <= '0;
                    r_idx   <= IDX_W'(w_row >> 3) * PIX_PER_ROW;
                    r_state <= ST_PIX;
                end
                ST_PIX: begin
                    if (w_issue) begin
                        r_x   <= r_x + 1'b1;
                        r_idx <= r_idx + 1'b1;
                        if (r_x == X_LAST) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_issue) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end

            if (w_move || w_status_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_zero <= (r_idx >= VRAM_SIZE);
            r_pend_last <= (r_x == X_LAST);
            r_pend_bit  <= r_row[2:0];
        end
        if (w_move) begin
            r_out_sync   <= r_sync;
            r_out_pixel  <= !r_pend_zero && w_rd_data[r_pend_bit];
            r_out_pvalid <= 1'b1;
            r_out_tick   <= 1'b0;
            r_out_last   <= r_pend_last;
        end else if (w_status_load) begin
            r_out_sync   <= n_sync;
            r_out_pixel  <= 1'b0;
            r_out_pvalid <= 1'b0;
            r_out_tick   <= !w_blank && w_wrap;
            r_out_last   <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_tick, r_out_pixel, r_out_sync};
    assign m_axis_tuser  = r_out_pvalid;
    assign m_axis_tlast  = r_out_last;

    // a status result is always the only one of its line
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("status result without last");

    a_status_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[1])
        else $error("pixel set on a status result");

    // a stalled fetch must keep its read data
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && !w_out_free |=> r_pend && $stable(w_rd_data))
        else $error("pending pixel read lost under stall");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PIX |-> r_x <= X_LAST)
        else $error("pixel counter past line width");

endmodule

### src/cvlg_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module cvlg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 96,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
